[hw/rtl/site_pattern_admixture_weighting_core_defines.svh]
// Assertion macros used by the checker file of the admixture weighting core.
// No dependencies.
`ifndef SITE_PATTERN_ADMIXTURE_WEIGHTING_CORE_DEFINES_SVH
`define SITE_PATTERN_ADMIXTURE_WEIGHTING_CORE_DEFINES_SVH
// Implication checked on every edge outside reset.
`define SPAW_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define SPAW_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

[hw/rtl/spaw_pkg.sv]
// Package for the admixture weighting core: widths, codes and state types.
// No dependencies.
package spaw_pkg;
  localparam int VW = 17;
  localparam int MAX_POPS = 4;
  localparam int FRAC_BITS = 16;
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_FREQ = 1'b1;
  localparam logic [1:0] CFG_NUM_POPS = 2'd0;
  localparam logic [1:0] CFG_USE_SINGLE = 2'd1;
  localparam logic [1:0] CFG_ADMIX = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DEN, ST_DIV, ST_PAT, ST_MUL, ST_WMUL, ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    MUL_NONE, MUL_DEN, MUL_PROD, MUL_WGT
  } mul_op_t;
endpackage

[hw/rtl/spaw_mul.sv]
// Shared registered multiplier with optional fixed-point rounding.
// No dependencies.
module spaw_mul #(
  parameter int FRAC_BITS = 16
) (
  input  logic                   clk,
  input  logic [FRAC_BITS:0]     a,
  input  logic [FRAC_BITS:0]     b,
  input  logic                   round_en,
  output logic [2*FRAC_BITS+1:0] prod_r,
  output logic [FRAC_BITS+1:0]   frac_r
);
  localparam int PW = 2 * FRAC_BITS + 2;
  logic [PW-1:0] p;
  logic [PW-1:0] pr;
  assign p  = PW'(a) * PW'(b);
  assign pr = p + (round_en ? (PW'(1) << (FRAC_BITS - 1)) : PW'(0));
  always_ff @(posedge clk) begin
    prod_r <= p;
    frac_r <= pr[FRAC_BITS +: FRAC_BITS + 2];
  end
endmodule

[hw/rtl/spaw_div.sv]
// Restoring divider, one quotient bit per cycle, rounded to nearest.
// No dependencies.
module spaw_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [2*FRAC_BITS+1:0] num,
  input  logic [2*FRAC_BITS+1:0] den,
  output logic                   done,
  output logic [FRAC_BITS:0]     quo
);
  localparam int DW = 2 * FRAC_BITS + 3;
  localparam int CW = $clog2(FRAC_BITS + 2);
  logic [DW-1:0] rem_r, rem_nxt, den_r, den_nxt, sh;
  logic [FRAC_BITS+1:0] q_r, q_nxt, qr;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt;

  always_comb begin
    rem_nxt = rem_r;
    den_nxt = den_r;
    q_nxt = q_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    sh = rem_r << 1;
    if (start) begin
      den_nxt = DW'(den);
      if (num >= den) begin
        q_nxt = (FRAC_BITS + 2)'(1);
        rem_nxt = DW'(num) - DW'(den);
      end else begin
        q_nxt = '0;
        rem_nxt = DW'(num);
      end
      cnt_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (sh >= den_r) begin
        rem_nxt = sh - den_r;
        q_nxt = {q_r[FRAC_BITS:0], 1'b1};
      end else begin
        rem_nxt = sh;
        q_nxt = {q_r[FRAC_BITS:0], 1'b0};
      end
      cnt_nxt = cnt_r + CW'(1);
      if (cnt_r == CW'(FRAC_BITS - 1)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    q_r <= q_nxt;
    cnt_r <= cnt_nxt;
  end

  assign done = busy_r && !busy_nxt;
  always_comb begin
    qr = q_nxt + ((rem_nxt >= den_r - rem_nxt) ? (FRAC_BITS + 2)'(1) : '0);
    quo = (qr > (FRAC_BITS + 2)'(1 << FRAC_BITS)) ? (FRAC_BITS + 1)'(1 << FRAC_BITS)
                                                   : qr[FRAC_BITS:0];
  end
endmodule

[hw/rtl/site_pattern_admixture_weighting_core.sv]
// Site-pattern admixture weighting core. A frequency item is stored when it
// is taken. A load item forms its weight through the shared multiplier and then
// the bit-serial divider. An item marked last then walks the patterns through
// one shared multiplier, one multiply per population in use plus one by the
// pattern weight for each legal pattern, and then waits for the result
// handshake. The core takes no item while one is in work. Depends on
// spaw_pkg, spaw_mul, spaw_div.
module site_pattern_admixture_weighting_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_operation,
  input  logic [3:0]  in_pattern,
  input  logic [16:0] in_prob_no_admix,
  input  logic [16:0] in_prob_admix,
  input  logic [1:0]  in_pop_index,
  input  logic [16:0] in_frequency,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [16:0] out_admix_prob,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [16:0] cfg_data
);
  localparam int MAX_POPS  = spaw_pkg::MAX_POPS;
  localparam int FRAC_BITS = spaw_pkg::FRAC_BITS;
  localparam int FW = FRAC_BITS + 1;
  localparam int NPAT = 1 << MAX_POPS;
  localparam int PB = MAX_POPS;
  localparam int JB = $clog2(MAX_POPS + 1);
  localparam int AW = FRAC_BITS + 2 + PB;
  localparam logic [FW-1:0] ONE = FW'(1) << FRAC_BITS;

  spaw_pkg::state_t st_r, st_nxt;
  logic [2:0]    num_pops_r;
  logic          use_single_r;
  logic [16:0]   admix_r;
  logic [FW-1:0] wt_r [NPAT];
  logic [FW-1:0] fq_r [MAX_POPS];
  logic [PB-1:0] pidx_r, pidx_nxt;
  logic [PB:0]   pat_r, pat_nxt;
  logic [JB-1:0] j_r, j_nxt;
  logic          ph_r, ph_nxt;
  logic [FW-1:0] z_r, z_nxt;
  logic [AW-1:0] acc_r, acc_nxt;
  logic [FW-1:0] p0_r, p1_r, a_s;
  logic          last_r;
  logic [16:0]   res_r;
  logic [JB-1:0] m;
  logic [PB:0]   full;
  logic [FW-1:0] ma, mb, fj;
  logic          mround;
  logic [2*FRAC_BITS+1:0] prod_r, num_r;
  logic [FRAC_BITS+1:0] frac_r;
  logic          div_start, div_done;
  logic [FW-1:0] quo;
  logic          legal;
  logic          accept;

  function automatic logic [FW-1:0] sat(input logic [16:0] v);
    logic [FW+16:0] w;
    w = (FW + 17)'(v);
    return (w > (FW + 17)'(ONE)) ? ONE : w[FW-1:0];
  endfunction

  assign accept = in_valid && !in_stall;
  assign in_stall = (st_r != spaw_pkg::ST_IDLE);
  assign cfg_ready = (st_r == spaw_pkg::ST_IDLE) && !in_valid;
  assign out_valid = (st_r == spaw_pkg::ST_OUT);
  assign out_admix_prob = res_r;
  assign a_s = sat(admix_r);
  assign m = (num_pops_r > 3'(MAX_POPS)) ? JB'(MAX_POPS) : JB'(num_pops_r);
  assign full = (PB + 1)'((1 << m) - 1);
  assign fj = fq_r[j_r[$clog2(MAX_POPS)-1:0]];
  assign legal = (pat_r < full) &&
                 (use_single_r || ((pat_r & (pat_r - (PB + 1)'(1))) != '0));

  always_comb begin
    ma = '0;
    mb = '0;
    mround = 1'b1;
    case (st_r)
      spaw_pkg::ST_DEN: begin
        ma = ph_r ? (ONE - a_s) : a_s;
        mb = ph_r ? p0_r : p1_r;
        mround = 1'b0;
      end
      spaw_pkg::ST_MUL: begin
        ma = z_r;
        mb = pat_r[j_r] ? fj : ONE - fj;
      end
      spaw_pkg::ST_WMUL: begin
        ma = z_r;
        mb = wt_r[pat_r[PB-1:0]];
      end
      default: ;
    endcase
  end

  spaw_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk(clk), .a(ma), .b(mb), .round_en(mround), .prod_r(prod_r), .frac_r(frac_r)
  );

  spaw_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(num_r),
    .den(prod_r + num_r), .done(div_done), .quo(quo)
  );

  always_comb begin
    st_nxt = st_r;
    pat_nxt = pat_r;
    j_nxt = j_r;
    ph_nxt = ph_r;
    z_nxt = z_r;
    acc_nxt = acc_r;
    pidx_nxt = pidx_r;
    div_start = 1'b0;
    case (st_r)
      spaw_pkg::ST_IDLE: begin
        if (accept) begin
          pidx_nxt = in_pattern[PB-1:0];
          ph_nxt = 1'b0;
          pat_nxt = (PB + 1)'(1);
          acc_nxt = '0;
          if (in_operation == spaw_pkg::OP_LOAD) st_nxt = spaw_pkg::ST_DEN;
          else if (in_last) st_nxt = spaw_pkg::ST_PAT;
        end
      end
      spaw_pkg::ST_DEN: begin
        ph_nxt = !ph_r;
        if (ph_r) st_nxt = spaw_pkg::ST_DIV;
      end
      spaw_pkg::ST_DIV: begin
        if (!ph_r) begin
          div_start = (prod_r + num_r) != '0;
          ph_nxt = div_start;
        end
        if ((!ph_r && (prod_r + num_r) == '0) || div_done) begin
          ph_nxt = 1'b0;
          pat_nxt = (PB + 1)'(1);
          st_nxt = last_r ? spaw_pkg::ST_PAT : spaw_pkg::ST_IDLE;
        end
      end
      spaw_pkg::ST_PAT: begin
        j_nxt = '0;
        ph_nxt = 1'b0;
        z_nxt = ONE;
        if (pat_r >= full) st_nxt = spaw_pkg::ST_OUT;
        else if (legal) st_nxt = spaw_pkg::ST_MUL;
        else pat_nxt = pat_r + (PB + 1)'(1);
      end
      spaw_pkg::ST_MUL: begin
        if (j_r == m) begin
          st_nxt = spaw_pkg::ST_WMUL;
        end else begin
          ph_nxt = !ph_r;
          if (ph_r) begin
            z_nxt = frac_r[FW-1:0];
            j_nxt = j_r + JB'(1);
          end
        end
      end
      spaw_pkg::ST_WMUL: begin
        ph_nxt = !ph_r;
        if (ph_r) begin
          acc_nxt = acc_r + AW'(frac_r[FW-1:0]);
          pat_nxt = pat_r + (PB + 1)'(1);
          st_nxt = spaw_pkg::ST_PAT;
        end
      end
      spaw_pkg::ST_OUT: begin
        if (!out_stall) st_nxt = spaw_pkg::ST_IDLE;
      end
      default: st_nxt = spaw_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= spaw_pkg::ST_IDLE;
      num_pops_r <= 3'd4;
      use_single_r <= 1'b0;
      admix_r <= '0;
      for (int i = 0; i < NPAT; i++) wt_r[i] <= '0;
      for (int i = 0; i < MAX_POPS; i++) fq_r[i] <= '0;
      ph_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      ph_r <= ph_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          spaw_pkg::CFG_NUM_POPS: num_pops_r <= cfg_data[2:0];
          spaw_pkg::CFG_USE_SINGLE: use_single_r <= cfg_data[0];
          spaw_pkg::CFG_ADMIX: admix_r <= cfg_data;
          default: ;
        endcase
      end
      if (accept && in_operation == spaw_pkg::OP_FREQ &&
          32'(in_pop_index) < MAX_POPS)
        fq_r[in_pop_index[$clog2(MAX_POPS)-1:0]] <= sat(in_frequency);
      if (st_r == spaw_pkg::ST_DIV && !ph_r && (prod_r + num_r) == '0)
        wt_r[pidx_r] <= '0;
      if (st_r == spaw_pkg::ST_DIV && ph_r && div_done) wt_r[pidx_r] <= quo;
    end
    pidx_r <= pidx_nxt;
    pat_r <= pat_nxt;
    j_r <= j_nxt;
    z_r <= z_nxt;
    acc_r <= acc_nxt;
    if (accept) begin
      p0_r <= sat(in_prob_no_admix);
      p1_r <= sat(in_prob_admix);
      last_r <= in_last;
    end
    if (st_r == spaw_pkg::ST_DEN && ph_r) num_r <= prod_r;
    if (st_r == spaw_pkg::ST_PAT && pat_r >= full)
      res_r <= (acc_r > AW'(ONE)) ? 17'(ONE) : 17'(acc_r);
  end
endmodule

[hw/rtl/spaw_checker.sv]
// Port-level checker for the admixture weighting core, bound to the top level.
// Depends on site_pattern_admixture_weighting_core_defines.svh.
`include "site_pattern_admixture_weighting_core_defines.svh"
module spaw_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [16:0] out_admix_prob,
  input logic        cfg_ready
);
  `SPAW_ASSERT_IMP(a_sat, clk, rst_n, out_valid, out_admix_prob <= 17'h10000, "result above one")
  `SPAW_ASSERT_IMP(a_busy, clk, rst_n, out_valid, in_stall, "item taken during output")
  `SPAW_ASSERT_IMP(a_cfg, clk, rst_n, cfg_ready, !in_stall, "config during work")
  `SPAW_ASSERT_NXT(a_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_admix_prob), "result dropped")
endmodule

bind site_pattern_admixture_weighting_core spaw_checker u_spaw_checker (
  .clk(clk), .rst_n(rst_n), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_admix_prob(out_admix_prob),
  .cfg_ready(cfg_ready)
);

[tb/testbench.sv]
// Self-checking testbench for site_pattern_admixture_weighting_core: random and directed items,
// a built-in predictor of the per-site admixture probability, and a result checker.
// Depends on spaw_pkg and the core RTL.
`timescale 1ns / 1ps
module testbench;
  localparam int NPOP = 4;
  localparam logic [16:0] ONE = 17'd65536;

  typedef struct packed {
    logic        operation;
    logic [3:0]  pattern;
    logic [16:0] p0;
    logic [16:0] p1;
    logic [1:0]  pop;
    logic [16:0] freq;
    logic        last;
  } site_item_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_operation = 1'b0;
  logic [3:0] in_pattern = '0;
  logic [16:0] in_prob_no_admix = '0;
  logic [16:0] in_prob_admix = '0;
  logic [1:0] in_pop_index = '0;
  logic [16:0] in_frequency = '0;
  logic in_last = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [16:0] out_admix_prob;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [16:0] cfg_data = '0;

  site_pattern_admixture_weighting_core u_top (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  site_item_t pending_items[$];
  logic [16:0] expected_probs[$];
  int errors = 0;
  int cycle_count = 0;
  bit quiet_mode = 1'b0;
  bit feed_hold = 1'b1;

  logic [2:0] mdl_num_pops;
  logic mdl_single;
  logic [16:0] mdl_admix;
  logic [16:0] mdl_weights[16];
  logic [16:0] mdl_freqs[NPOP];

  function automatic logic [63:0] clamp_one(input logic [63:0] v);
    return (v > 64'(ONE)) ? 64'(ONE) : v;
  endfunction

  function automatic logic [63:0] qmul(input logic [63:0] x, input logic [63:0] y);
    return (x * y + 64'd32768) >> 16;
  endfunction

  function automatic logic [63:0] bayes_weight(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [63:0] r;
    q = (num >= den) ? 64'd1 : 64'd0;
    r = num - q * den;
    for (int i = 0; i < 16; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= den) begin
        r = r - den;
        q = q | 64'd1;
      end
    end
    if (r >= den - r) q = q + 64'd1;
    return clamp_one(q);
  endfunction

  function automatic logic [16:0] site_admix_prob();
    logic [63:0] m;
    logic [63:0] acc;
    logic [63:0] z;
    logic [63:0] f;
    m = (mdl_num_pops > NPOP) ? 64'(NPOP) : 64'(mdl_num_pops);
    acc = 64'd0;
    for (int pat = 1; pat < (1 << m) - 1; pat++) begin
      if (!mdl_single && ((pat & (pat - 1)) == 0)) continue;
      z = 64'(ONE);
      for (int j = 0; j < m; j++) begin
        f = 64'(mdl_freqs[j]);
        z = qmul(z, ((pat >> j) & 1) ? f : 64'(ONE) - f);
      end
      acc = acc + qmul(z, 64'(mdl_weights[pat[3:0]]));
    end
    return 17'(clamp_one(acc));
  endfunction

  task automatic predict_item(input site_item_t it);
    logic [63:0] a;
    logic [63:0] p0;
    logic [63:0] p1;
    logic [63:0] num;
    logic [63:0] den;
    if (it.operation == spaw_pkg::OP_LOAD) begin
      a = clamp_one(64'(mdl_admix));
      p0 = clamp_one(64'(it.p0));
      p1 = clamp_one(64'(it.p1));
      num = a * p1;
      den = (64'(ONE) - a) * p0 + num;
      mdl_weights[it.pattern] = (den == 0) ? 17'd0 : 17'(bayes_weight(num, den));
    end else begin
      mdl_freqs[it.pop] = 17'(clamp_one(64'(it.freq)));
    end
    if (it.last) expected_probs.push_back(site_admix_prob());
  endtask

  function automatic logic [16:0] rand_q16();
    case ($urandom_range(0, 9))
      0: return 17'd0;
      1: return ONE;
      2: return 17'($urandom_range(65537, 131071));
      default: return 17'($urandom_range(0, 65536));
    endcase
  endfunction

  function automatic site_item_t rand_item(input bit well_formed);
    site_item_t it;
    it.operation = 1'($urandom_range(0, 1));
    it.pattern = 4'($urandom);
    it.p0 = rand_q16();
    it.p1 = rand_q16();
    it.pop = 2'($urandom);
    it.freq = rand_q16();
    it.last = well_formed ? 1'b0 : 1'($urandom_range(0, 3) == 0);
    return it;
  endfunction

  function automatic site_item_t make_item(input logic op, input logic [3:0] pat,
      input logic [16:0] p0, input logic [16:0] p1, input logic [1:0] pop,
      input logic [16:0] freq, input logic last);
    site_item_t it;
    it = '{op, pat, p0, p1, pop, freq, last};
    return it;
  endfunction

  // Driver: accepts at edges with valid high and stall low.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        predict_item('{in_operation, in_pattern, in_prob_no_admix, in_prob_admix,
                       in_pop_index, in_frequency, in_last});
        pending_items.pop_front();
      end
      if ((!in_valid || !in_stall) || !in_valid) begin
        if ((in_valid && !in_stall) || !in_valid) begin
          if (pending_items.size() > 0 && !feed_hold &&
              (quiet_mode || $urandom_range(0, 99) >= 7)) begin
            site_item_t nx;
            nx = pending_items[0];
            in_valid <= 1'b1;
            in_operation <= nx.operation;
            in_pattern <= nx.pattern;
            in_prob_no_admix <= nx.p0;
            in_prob_admix <= nx.p1;
            in_pop_index <= nx.pop;
            in_frequency <= nx.freq;
            in_last <= nx.last;
          end else begin
            in_valid <= 1'b0;
          end
        end
      end
      out_stall <= !quiet_mode && ($urandom_range(0, 99) < 7);
    end
  end

  // Monitor.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_probs.size() == 0) begin
        $display("%0t: unexpected result admix_prob actual %0d", $time, out_admix_prob);
        errors <= errors + 1;
      end else begin
        if (out_admix_prob !== expected_probs[0]) begin
          $display("%0t: admix_prob mismatch expected %0d actual %0d", $time,
                   expected_probs[0], out_admix_prob);
          errors <= errors + 1;
        end
        expected_probs.pop_front();
      end
    end
  end

  always @(posedge clk) begin
    if (cycle_count > 2000000) begin
      $display("site_pattern_admixture_weighting_core regression: fail");
      $finish;
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [16:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      spaw_pkg::CFG_NUM_POPS: mdl_num_pops = val[2:0];
      spaw_pkg::CFG_USE_SINGLE: mdl_single = val[0];
      spaw_pkg::CFG_ADMIX: mdl_admix = val;
      default: ;
    endcase
  endtask

  task automatic run_batch();
    feed_hold = 1'b0;
    while (pending_items.size() != 0 || in_valid) @(posedge clk);
    feed_hold = 1'b1;
    while (expected_probs.size() != 0) @(posedge clk);
    repeat (250) @(posedge clk);
  endtask

  // Random sites: a run of frequency and load items, some marked last at random.
  task automatic queue_sites(input int count);
    site_item_t it;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 9) < 8) begin
        it = rand_item(1'b1);
        if ($urandom_range(0, 3) == 0) it.last = 1'b1;
      end else begin
        it = rand_item(1'b0);
      end
      pending_items.push_back(it);
    end
  endtask

  initial begin
    mdl_num_pops = 3'd4;
    mdl_single = 1'b0;
    mdl_admix = '0;
    foreach (mdl_weights[i]) mdl_weights[i] = '0;
    foreach (mdl_freqs[i]) mdl_freqs[i] = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    pending_items.push_back(make_item(spaw_pkg::OP_FREQ, 4'd0, 17'd0, 17'd0, 2'd0, 17'd30000,
                                      1'b1));
    run_batch();
    write_reg(spaw_pkg::CFG_ADMIX, 17'd20000);
    write_reg(spaw_pkg::CFG_USE_SINGLE, 17'd1);
    for (int p = 0; p < 16; p++)
      pending_items.push_back(make_item(spaw_pkg::OP_LOAD, 4'(p), 17'(p * 4000),
                                        17'(65536 - p * 4000), 2'd0, 17'd0, 1'b0));
    pending_items.push_back(make_item(spaw_pkg::OP_LOAD, 4'd5, 17'd0, 17'd0, 2'd0, 17'd0,
                                      1'b1));
    pending_items.push_back(make_item(spaw_pkg::OP_LOAD, 4'd6, 17'h1FFFF, 17'h1FFFF, 2'd0,
                                      17'd0, 1'b0));
    pending_items.push_back(make_item(spaw_pkg::OP_FREQ, 4'd0, 17'd0, 17'd0, 2'd0, ONE, 1'b0));
    pending_items.push_back(make_item(spaw_pkg::OP_FREQ, 4'd0, 17'd0, 17'd0, 2'd1, 17'h1FFFF,
                                      1'b0));
    pending_items.push_back(make_item(spaw_pkg::OP_FREQ, 4'd0, 17'd0, 17'd0, 2'd2, 17'd0,
                                      1'b0));
    pending_items.push_back(make_item(spaw_pkg::OP_FREQ, 4'd0, 17'd0, 17'd0, 2'd3, 17'd32768,
                                      1'b1));
    run_batch();
    write_reg(spaw_pkg::CFG_NUM_POPS, 17'd7);
    write_reg(spaw_pkg::CFG_ADMIX, 17'h1FFFF);
    pending_items.push_back(make_item(spaw_pkg::OP_LOAD, 4'd3, 17'd100, 17'd200, 2'd0, 17'd0,
                                      1'b1));
    run_batch();
    write_reg(spaw_pkg::CFG_NUM_POPS, 17'd1);
    pending_items.push_back(make_item(spaw_pkg::OP_FREQ, 4'd0, 17'd0, 17'd0, 2'd1, 17'd5,
                                      1'b1));
    run_batch();
    write_reg(spaw_pkg::CFG_NUM_POPS, 17'd0);
    write_reg(2'd3, 17'd77);
    pending_items.push_back(make_item(spaw_pkg::OP_FREQ, 4'd0, 17'd0, 17'd0, 2'd1, 17'd5,
                                      1'b1));
    run_batch();

    for (int ph = 0; ph < 8; ph++) begin
      write_reg(spaw_pkg::CFG_NUM_POPS, 17'($urandom_range(2, 4)));
      if (ph == 1) write_reg(spaw_pkg::CFG_NUM_POPS, 17'd2);
      write_reg(spaw_pkg::CFG_USE_SINGLE, 17'($urandom_range(0, 1)));
      write_reg(spaw_pkg::CFG_ADMIX, (ph == 2) ? 17'd0 : (ph == 3) ? ONE : rand_q16());
      quiet_mode = (ph == 4);
      queue_sites(200);
      run_batch();
    end
    quiet_mode = 1'b0;

    if (errors == 0 && expected_probs.size() == 0) begin
      $display("site_pattern_admixture_weighting_core regression: pass");
    end else begin
      $display("site_pattern_admixture_weighting_core regression: fail");
    end
    $finish;
  end
endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/spaw_pkg.sv
hw/rtl/spaw_mul.sv
hw/rtl/spaw_div.sv
hw/rtl/site_pattern_admixture_weighting_core.sv
hw/rtl/spaw_checker.sv
tb/testbench.sv
